### hw/rtl/nbpa_pkg.sv
// Shared types and constants of the nested block profile aggregator.
// No dependencies; every other file of the block but the two channel interfaces imports this package.
package nbpa_pkg;

    localparam int THREADS_DEF     = 4;
    localparam int BLOCKS_DEF      = 256;
    localparam int FRAMES_DEF      = 60;
    localparam int STACK_DEPTH_DEF = 32;
    localparam int QUEUE_DEPTH     = 2;

    localparam int TS_W           = 64;
    localparam int SUM_W          = 32;
    localparam int MEAN_W         = 48;
    localparam int FRAC_W         = 16;
    localparam int DIVIDEND_W     = 80;
    localparam int DIVISOR_W      = 33;
    localparam int DIV_RADIX_BITS = 2;
    localparam int DIV_STEPS      = DIVIDEND_W / DIV_RADIX_BITS;

    typedef enum logic [1:0] {
        CMD_START = 2'd0,
        CMD_END   = 2'd1,
        CMD_FRAME = 2'd2,
        CMD_READ  = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_UNMATCHED = 2'd1,
        ST_FULL      = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        F_IDLE,
        F_LOOK,
        F_EXEC,
        F_PUSH
    } f_state_t;

    typedef enum logic [2:0] {
        B_CLEAR,
        B_IDLE,
        B_RD,
        B_CALC,
        B_SUM,
        B_DIV,
        B_SWEEP
    } b_state_t;

    // Classified event handed from the stack front end to the statistics back end.
    typedef struct packed {
        cmd_t             cmd;
        logic [1:0]       thread;
        logic [7:0]       block;
        status_t          status;
        logic             live;
        logic [TS_W-1:0]  total;
        logic [TS_W-1:0]  self_time;
    } job_t;

    typedef struct packed {
        logic [TS_W-1:0]  start_time;
        logic [7:0]       block;
        logic [TS_W-1:0]  saved_sum;
    } stack_entry_t;

    typedef struct packed {
        logic [SUM_W-1:0] total;
        logic [SUM_W-1:0] self_time;
        logic [SUM_W-1:0] hits;
    } slot_t;

    typedef struct packed {
        logic [MEAN_W-1:0] mean;
        logic [TS_W-1:0]   hits;
        logic [SUM_W-1:0]  peak_total;
        logic [SUM_W-1:0]  peak_self;
        logic [SUM_W-1:0]  peak_hits;
    } row_t;

    typedef struct packed {
        logic [1:0]        status;
        logic [TS_W-1:0]   block_total;
        logic [TS_W-1:0]   block_self;
        logic [SUM_W-1:0]  frame_total;
        logic [SUM_W-1:0]  frame_self;
        logic [SUM_W-1:0]  frame_hits;
        logic [SUM_W-1:0]  peak_total;
        logic [SUM_W-1:0]  peak_self;
        logic [SUM_W-1:0]  peak_hits;
        logic [TS_W-1:0]   lifetime_hits;
        logic [MEAN_W-1:0] mean_self;
    } result_t;

endpackage

### hw/rtl/nbpa_event_if.sv
// Event channel of the profile aggregator: valid/ready plus one event.
// No dependencies.
interface nbpa_event_if;
    logic        valid;
    logic        ready;
    logic [1:0]  command;
    logic [1:0]  thread_index;
    logic [7:0]  block_num;
    logic [63:0] timestamp;

    modport source (output valid, command, thread_index, block_num, timestamp, input ready);
    modport sink (input valid, command, thread_index, block_num, timestamp, output ready);
endinterface

### hw/rtl/nbpa_result_if.sv
// Result channel of the profile aggregator: valid/ready plus one result.
// No dependencies.
interface nbpa_result_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [63:0] block_total;
    logic [63:0] block_self;
    logic [31:0] frame_total;
    logic [31:0] frame_self;
    logic [31:0] frame_hits;
    logic [31:0] peak_total;
    logic [31:0] peak_self;
    logic [31:0] peak_hits;
    logic [63:0] lifetime_hits;
    logic [47:0] mean_self;

    modport source (output valid, status, block_total, block_self, frame_total, frame_self,
                    frame_hits, peak_total, peak_self, peak_hits, lifetime_hits, mean_self,
                    input ready);
    modport sink (input valid, status, block_total, block_self, frame_total, frame_self,
                  frame_hits, peak_total, peak_self, peak_hits, lifetime_hits, mean_self,
                  output ready);
endinterface

### hw/rtl/nbpa_front.sv
// Front end: accepts events, keeps the per-thread stacks of open blocks and
// classifies each event into a job. Depends on nbpa_pkg and nbpa_event_if.
module nbpa_front #(
    parameter int THREADS     = nbpa_pkg::THREADS_DEF,
    parameter int STACK_DEPTH = nbpa_pkg::STACK_DEPTH_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            hold,
    nbpa_event_if.sink      events,
    output nbpa_pkg::job_t  job,
    output logic            job_valid,
    input  logic            job_ready
);
    import nbpa_pkg::*;

    localparam int TW     = (THREADS > 1) ? $clog2(THREADS) : 1;
    localparam int LW     = $clog2(STACK_DEPTH + 1);
    localparam int SDEPTH = THREADS * STACK_DEPTH;
    localparam int SAW    = $clog2(SDEPTH);

    f_state_t state_reg, state_next;

    cmd_t             cmd_reg;
    logic [1:0]       thr_reg;
    logic [7:0]       blk_reg;
    logic [TS_W-1:0]  cyc_reg;
    logic [LW-1:0]    level_reg [THREADS];
    logic [TS_W-1:0]  sib_reg   [THREADS];
    logic [TS_W-1:0]  child_reg [THREADS];
    stack_entry_t     stk_mem   [SDEPTH];
    stack_entry_t     stk_rd_reg;
    job_t             job_reg, job_next;

    logic             accept;
    logic [TW-1:0]    tix;
    logic             t_ok;
    logic [LW-1:0]    lvl;
    logic [LW-1:0]    stk_lvl;
    logic [SAW-1:0]   stk_addr;
    logic             start_ok;
    logic             end_ok;
    logic [TS_W-1:0]  total;
    logic [TS_W-1:0]  sib_sum;
    logic [TS_W-1:0]  self_c;

    assign tix      = TW'(thr_reg);
    assign t_ok     = 32'(thr_reg) < THREADS;
    assign lvl      = level_reg[tix];
    assign stk_lvl  = (cmd_reg == CMD_END) ? lvl - LW'(1) : lvl;
    assign stk_addr = SAW'(int'(tix) * STACK_DEPTH + int'(stk_lvl));
    assign start_ok = t_ok && (lvl != LW'(STACK_DEPTH));
    assign end_ok   = t_ok && (lvl != '0) && (stk_rd_reg.block == blk_reg);
    assign total    = cyc_reg - stk_rd_reg.start_time;
    assign sib_sum  = sib_reg[tix] + total;
    assign self_c   = total - child_reg[tix];

    always_comb
    begin
        job_next           = '0;
        job_next.cmd       = cmd_reg;
        job_next.thread    = thr_reg;
        job_next.block     = blk_reg;
        job_next.status    = ST_OK;
        case (cmd_reg)
            CMD_START:
            begin
                if (!start_ok)
                begin
                    job_next.status = ST_FULL;
                end
            end
            CMD_END:
            begin
                if (end_ok)
                begin
                    job_next.live      = 1'b1;
                    job_next.total     = total;
                    job_next.self_time = self_c;
                end
                else
                begin
                    job_next.status = ST_UNMATCHED;
                end
            end
            CMD_READ:
            begin
                job_next.live = t_ok;
            end
            default:
            begin
                job_next.live = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            F_IDLE:  if (accept) state_next = F_LOOK;
            F_LOOK:  state_next = F_EXEC;
            F_EXEC:  state_next = F_PUSH;
            F_PUSH:  if (job_ready) state_next = F_IDLE;
            default: state_next = F_IDLE;
        endcase
    end

    always_comb
    begin
        events.ready = (state_reg == F_IDLE) && !hold;
        job_valid    = (state_reg == F_PUSH);
    end

    assign accept = events.valid && events.ready;
    assign job    = job_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
            for (int i = 0; i < THREADS; i++)
            begin
                level_reg[i] <= '0;
                sib_reg[i]   <= '0;
                child_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == F_EXEC)
            begin
                if (cmd_reg == CMD_START && start_ok)
                begin
                    sib_reg[tix]   <= child_reg[tix];
                    child_reg[tix] <= '0;
                    level_reg[tix] <= lvl + LW'(1);
                end
                else if (cmd_reg == CMD_END && end_ok)
                begin
                    child_reg[tix] <= sib_sum;
                    sib_reg[tix]   <= stk_rd_reg.saved_sum;
                    level_reg[tix] <= lvl - LW'(1);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg <= cmd_t'(events.command);
            thr_reg <= events.thread_index;
            blk_reg <= events.block_num;
            cyc_reg <= events.timestamp;
        end
        if (state_reg == F_LOOK)
        begin
            stk_rd_reg <= stk_mem[stk_addr];
        end
        if (state_reg == F_EXEC)
        begin
            job_reg <= job_next;
            if (cmd_reg == CMD_START && start_ok)
            begin
                stk_mem[stk_addr] <= '{start_time: cyc_reg, block: blk_reg,
                                       saved_sum: sib_reg[tix]};
            end
        end
    end

endmodule

### hw/rtl/nbpa_queue.sv
// Short job queue between the front end and the back end.
// Depends on nbpa_pkg.
module nbpa_queue #(
    parameter int DEPTH = nbpa_pkg::QUEUE_DEPTH
) (
    input  logic            clk,
    input  logic            rst_n,
    input  nbpa_pkg::job_t  in_job,
    input  logic            in_valid,
    output logic            in_ready,
    output nbpa_pkg::job_t  out_job,
    output logic            out_valid,
    input  logic            out_ready
);
    import nbpa_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    job_t          mem_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0] count_reg;
    logic          push, pop;

    assign in_ready  = (count_reg != CW'(DEPTH));
    assign out_valid = (count_reg != '0);
    assign out_job   = mem_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + CW'(1);
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - CW'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= in_job;
        end
    end

endmodule

### hw/rtl/nbpa_div.sv
// Radix-4 restoring divider for the running mean: 80-bit dividend by a
// 33-bit divisor, two quotient bits per cycle. Depends on nbpa_pkg.
module nbpa_div (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic [nbpa_pkg::DIVIDEND_W-1:0] dividend,
    input  logic [nbpa_pkg::DIVISOR_W-1:0]  divisor,
    output logic                            done,
    output logic [nbpa_pkg::MEAN_W-1:0]     quotient
);
    import nbpa_pkg::*;

    localparam int CNT_W = $clog2(DIV_STEPS + 1);

    logic [DIVIDEND_W-1:0] work_reg, work_next;
    logic [DIVISOR_W-1:0]  rem_reg, rem_next;
    logic [DIVISOR_W-1:0]  den_reg;
    logic [CNT_W-1:0]      cnt_reg;
    logic                  busy_reg;
    logic                  done_reg;

    logic [DIVISOR_W:0]    trial;
    logic [DIVISOR_W-1:0]  r;
    logic [DIVIDEND_W-1:0] w;

    always_comb
    begin
        r     = rem_reg;
        w     = work_reg;
        trial = '0;
        for (int k = 0; k < DIV_RADIX_BITS; k++)
        begin
            trial = {r, w[DIVIDEND_W-1]};
            w     = {w[DIVIDEND_W-2:0], 1'b0};
            if (trial >= {1'b0, den_reg})
            begin
                trial = trial - {1'b0, den_reg};
                w[0]  = 1'b1;
            end
            r = trial[DIVISOR_W-1:0];
        end
        rem_next  = r;
        work_next = w;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(DIV_STEPS);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            work_reg <= dividend;
            rem_reg  <= '0;
            den_reg  <= divisor;
        end
        else if (busy_reg)
        begin
            work_reg <= work_next;
            rem_reg  <= rem_next;
        end
    end

    assign done     = done_reg;
    assign quotient = work_reg[MEAN_W-1:0];

endmodule

### hw/rtl/nbpa_back.sv
// Back end: owns the frame slot memory and the per-block statistics memory,
// applies jobs in order and drives the result channel.
// Depends on nbpa_pkg, nbpa_result_if and nbpa_div.
module nbpa_back #(
    parameter int THREADS = nbpa_pkg::THREADS_DEF,
    parameter int BLOCKS  = nbpa_pkg::BLOCKS_DEF,
    parameter int FRAMES  = nbpa_pkg::FRAMES_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  nbpa_pkg::job_t  job,
    input  logic            job_valid,
    output logic            job_ready,
    output logic            clearing,
    nbpa_result_if.source   results
);
    import nbpa_pkg::*;

    localparam int ROWS  = THREADS * BLOCKS;
    localparam int SLOTS = ROWS * FRAMES;
    localparam int RW    = $clog2(ROWS);
    localparam int SW    = $clog2(SLOTS);
    localparam int TW    = (THREADS > 1) ? $clog2(THREADS) : 1;
    localparam int FSW   = (FRAMES > 1) ? $clog2(FRAMES) : 1;

    b_state_t state_reg, state_next;

    job_t              job_reg;
    logic [SUM_W-1:0]  frame_number_reg;
    logic [FSW-1:0]    frame_slot_reg;
    logic [SW-1:0]     clr_reg;
    logic [SW-1:0]     sweep_addr_reg;
    logic [RW-1:0]     sweep_row_reg;
    slot_t             slot_mem [SLOTS];
    row_t              row_mem  [ROWS];
    slot_t             slot_rd_reg;
    row_t              row_rd_reg;
    row_t              row_new_reg;
    logic [63:0]       p0_reg;
    logic [47:0]       p1_reg;
    logic [SUM_W-1:0]  sat_reg;
    logic              out_valid_reg;
    result_t           res_reg;

    logic              pop;
    logic              head_row;
    logic [FSW-1:0]    slot_step;
    logic [TW-1:0]     tix;
    logic [RW-1:0]     row_idx;
    logic [SW-1:0]     slot_addr;
    slot_t             slot_upd;
    row_t              row_upd;
    logic [SUM_W-1:0]  self_sat;
    logic              clr_last;
    logic              sweep_last;

    logic              slot_wr_en;
    logic [SW-1:0]     slot_wr_addr;
    slot_t             slot_wr_data;
    logic              row_wr_en;
    logic [RW-1:0]     row_wr_addr;
    row_t              row_wr_data;
    logic              post;
    result_t           res_next;

    logic                  div_start;
    logic [DIVIDEND_W-1:0] dividend;
    logic [DIVISOR_W-1:0]  divisor;
    logic                  div_done;
    logic [MEAN_W-1:0]     quotient;

    nbpa_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (dividend),
        .divisor  (divisor),
        .done     (div_done),
        .quotient (quotient)
    );

    assign head_row  = (job.cmd == CMD_END || job.cmd == CMD_READ) && job.live
                       && (32'(job.block) < BLOCKS);
    assign pop       = (state_reg == B_IDLE) && !out_valid_reg && job_valid;
    assign slot_step = (frame_slot_reg == FSW'(FRAMES - 1)) ? '0 : frame_slot_reg + FSW'(1);
    assign tix       = TW'(job_reg.thread);
    assign row_idx   = RW'(int'(tix) * BLOCKS + int'(job_reg.block));
    assign slot_addr = SW'(int'(row_idx) * FRAMES + int'(frame_slot_reg));
    assign clr_last   = (clr_reg == SW'(SLOTS - 1));
    assign sweep_last = (sweep_row_reg == RW'(ROWS - 1));

    // Saturate self time to 32 bits for the mean.
    assign self_sat = (|job_reg.self_time[63:32]) ? '1 : job_reg.self_time[31:0];

    always_comb
    begin
        slot_upd.total     = slot_rd_reg.total + job_reg.total[31:0];
        slot_upd.self_time = slot_rd_reg.self_time + job_reg.self_time[31:0];
        slot_upd.hits      = slot_rd_reg.hits + SUM_W'(1);
        row_upd.mean       = row_rd_reg.mean;
        row_upd.hits       = row_rd_reg.hits + TS_W'(1);
        row_upd.peak_total = (row_rd_reg.peak_total < slot_upd.total) ?
                             slot_upd.total : row_rd_reg.peak_total;
        row_upd.peak_self  = (row_rd_reg.peak_self < slot_upd.self_time) ?
                             slot_upd.self_time : row_rd_reg.peak_self;
        row_upd.peak_hits  = (row_rd_reg.peak_hits < slot_upd.hits) ?
                             slot_upd.hits : row_rd_reg.peak_hits;
    end

    assign dividend = {p1_reg, 32'd0} + DIVIDEND_W'(p0_reg)
                      + DIVIDEND_W'({sat_reg, 16'd0});
    assign divisor  = {1'b0, frame_number_reg} + DIVISOR_W'(1);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            B_CLEAR: if (clr_last) state_next = B_IDLE;
            B_IDLE:
            begin
                if (pop)
                begin
                    if (head_row)
                    begin
                        state_next = B_RD;
                    end
                    else if (job.cmd == CMD_FRAME)
                    begin
                        state_next = B_SWEEP;
                    end
                end
            end
            B_RD:    state_next = B_CALC;
            B_CALC:  state_next = (job_reg.cmd == CMD_READ) ? B_IDLE : B_SUM;
            B_SUM:   state_next = B_DIV;
            B_DIV:   if (div_done) state_next = B_IDLE;
            B_SWEEP: if (sweep_last) state_next = B_IDLE;
            default: state_next = B_IDLE;
        endcase
    end

    always_comb
    begin
        job_ready    = pop;
        clearing     = (state_reg == B_CLEAR);
        div_start    = (state_reg == B_SUM);
        slot_wr_en   = 1'b0;
        slot_wr_addr = slot_addr;
        slot_wr_data = slot_upd;
        row_wr_en    = 1'b0;
        row_wr_addr  = row_idx;
        row_wr_data  = row_new_reg;
        row_wr_data.mean = quotient;
        post         = 1'b0;
        res_next     = '0;
        case (state_reg)
            B_CLEAR:
            begin
                slot_wr_en   = 1'b1;
                slot_wr_addr = clr_reg;
                slot_wr_data = '0;
                row_wr_en    = int'(clr_reg) < ROWS;
                row_wr_addr  = clr_reg[RW-1:0];
                row_wr_data  = '0;
            end
            B_IDLE:
            begin
                if (pop && !head_row)
                begin
                    post                 = 1'b1;
                    res_next.status      = job.status;
                    res_next.block_total = job.total;
                    res_next.block_self  = job.self_time;
                end
            end
            B_CALC:
            begin
                if (job_reg.cmd == CMD_READ)
                begin
                    post                   = 1'b1;
                    res_next.frame_total   = slot_rd_reg.total;
                    res_next.frame_self    = slot_rd_reg.self_time;
                    res_next.frame_hits    = slot_rd_reg.hits;
                    res_next.peak_total    = row_rd_reg.peak_total;
                    res_next.peak_self     = row_rd_reg.peak_self;
                    res_next.peak_hits     = row_rd_reg.peak_hits;
                    res_next.lifetime_hits = row_rd_reg.hits;
                    res_next.mean_self     = row_rd_reg.mean;
                end
                else
                begin
                    slot_wr_en = 1'b1;
                end
            end
            B_DIV:
            begin
                if (div_done)
                begin
                    row_wr_en            = 1'b1;
                    post                 = 1'b1;
                    res_next.status      = job_reg.status;
                    res_next.block_total = job_reg.total;
                    res_next.block_self  = job_reg.self_time;
                end
            end
            B_SWEEP:
            begin
                slot_wr_en   = 1'b1;
                slot_wr_addr = sweep_addr_reg;
                slot_wr_data = '0;
            end
            default:
            begin
                post = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= B_CLEAR;
            frame_number_reg <= '0;
            frame_slot_reg   <= '0;
            clr_reg          <= '0;
            sweep_addr_reg   <= '0;
            sweep_row_reg    <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == B_CLEAR)
            begin
                clr_reg <= clr_reg + SW'(1);
            end
            if (pop && job.cmd == CMD_FRAME)
            begin
                frame_number_reg <= frame_number_reg + SUM_W'(1);
                frame_slot_reg   <= slot_step;
                sweep_addr_reg   <= SW'(slot_step);
                sweep_row_reg    <= '0;
            end
            else if (state_reg == B_SWEEP)
            begin
                sweep_addr_reg <= sweep_addr_reg + SW'(FRAMES);
                sweep_row_reg  <= sweep_row_reg + RW'(1);
            end
            if (post)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (results.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (slot_wr_en)
        begin
            slot_mem[slot_wr_addr] <= slot_wr_data;
        end
        if (row_wr_en)
        begin
            row_mem[row_wr_addr] <= row_wr_data;
        end
        if (state_reg == B_RD)
        begin
            slot_rd_reg <= slot_mem[slot_addr];
            row_rd_reg  <= row_mem[row_idx];
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            job_reg <= job;
        end
        if (state_reg == B_CALC)
        begin
            row_new_reg <= row_upd;
            p0_reg      <= row_rd_reg.mean[31:0] * frame_number_reg;
            p1_reg      <= row_rd_reg.mean[47:32] * frame_number_reg;
            sat_reg     <= self_sat;
        end
        if (post)
        begin
            res_reg <= res_next;
        end
    end

    assign results.valid         = out_valid_reg;
    assign results.status        = res_reg.status;
    assign results.block_total   = res_reg.block_total;
    assign results.block_self    = res_reg.block_self;
    assign results.frame_total   = res_reg.frame_total;
    assign results.frame_self    = res_reg.frame_self;
    assign results.frame_hits    = res_reg.frame_hits;
    assign results.peak_total    = res_reg.peak_total;
    assign results.peak_self     = res_reg.peak_self;
    assign results.peak_hits     = res_reg.peak_hits;
    assign results.lifetime_hits = res_reg.lifetime_hits;
    assign results.mean_self     = res_reg.mean_self;

endmodule

### hw/rtl/nested_block_profile_aggregator.sv
// Nested block profile aggregator. The front end takes one event at a time,
// passing it through its look-up, execute and push states before it accepts
// the next, and keeps the open-block stacks; a two-entry job queue feeds the
// back end, which owns the statistics memories. A start, an error, or a read
// of an unknown thread or block is answered from the back end's idle state.
// A read also passes through the memory read and calculate states; a matched
// end of a known block then waits for the two-bit-per-cycle divider that
// updates the running mean. End of frame sweeps the new frame slot of every
// block (1024 rows by default). After reset the back end zeroes its memories
// and no event is accepted until that finishes. Depends on nbpa_pkg, the two
// channel interfaces, nbpa_front, nbpa_queue and nbpa_back.
module nested_block_profile_aggregator #(
    parameter int THREADS     = nbpa_pkg::THREADS_DEF,
    parameter int BLOCKS      = nbpa_pkg::BLOCKS_DEF,
    parameter int FRAMES      = nbpa_pkg::FRAMES_DEF,
    parameter int STACK_DEPTH = nbpa_pkg::STACK_DEPTH_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    nbpa_event_if.sink    events,
    nbpa_result_if.source results
);
    import nbpa_pkg::*;

    job_t front_job, queue_job;
    logic front_valid, front_ready;
    logic queue_valid, queue_ready;
    logic clearing;

    nbpa_front #(
        .THREADS     (THREADS),
        .STACK_DEPTH (STACK_DEPTH)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .hold      (clearing),
        .events    (events),
        .job       (front_job),
        .job_valid (front_valid),
        .job_ready (front_ready)
    );

    nbpa_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_job    (front_job),
        .in_valid  (front_valid),
        .in_ready  (front_ready),
        .out_job   (queue_job),
        .out_valid (queue_valid),
        .out_ready (queue_ready)
    );

    nbpa_back #(
        .THREADS (THREADS),
        .BLOCKS  (BLOCKS),
        .FRAMES  (FRAMES)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job       (queue_job),
        .job_valid (queue_valid),
        .job_ready (queue_ready),
        .clearing  (clearing),
        .results   (results)
    );

endmodule
